// ----- rtl/assert_macros.svh -----
// Assertion macros for the min window sum length block.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, prop)
`define ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ----- rtl/mwsl_pkg.sv -----
// Shared types and constants for the min window sum length block.
// Depends on nothing.
package mwsl_pkg;

    localparam int VALUE_W  = 16;
    localparam int TARGET_W = 26;
    localparam int LEN_W    = 11;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic [LEN_W-1:0] min_length;
        logic             overflow;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT
    } state_t;

endpackage

// ----- rtl/mwsl_store.sv -----
// Window store: single write port, single read port, registered read.
// Depends on nothing.
module mwsl_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/min_window_sum_length.sv -----
// Flow: each accepted sample word is followed by a check of the window; each element removed
// from the window front waits on one read of the window store (registered read), and a new
// sample word is not taken until the removals and any pending result word are done.
// Reset: asynchronous, active low; clears pointers, sum, flags and result valid, target to 1.
// The window store is not cleared; only entries written in the current sequence are read.
`include "assert_macros.svh"

module min_window_sum_length #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  mwsl_pkg::sample_t              sample,
    output logic                           result_valid,
    input  logic                           result_stall,
    output mwsl_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mwsl_pkg::TARGET_W-1:0]  cfg_data
);

    localparam int POS_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int SUM_W  = POS_W + mwsl_pkg::VALUE_W;
    localparam int CMP_W  = (SUM_W > mwsl_pkg::TARGET_W) ? SUM_W : mwsl_pkg::TARGET_W;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_ITEMS);

    mwsl_pkg::state_t state_reg, state_next;

    logic [POS_W-1:0]              front_reg, front_next;
    logic [POS_W-1:0]              back_reg, back_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [POS_W-1:0]              best_reg, best_next;
    logic                          found_reg, found_next;
    logic                          ovf_reg, ovf_next;
    logic                          last_reg, last_next;
    logic [mwsl_pkg::TARGET_W-1:0] target_reg;
    logic                          result_valid_reg, result_valid_next;
    mwsl_pkg::result_t             result_reg, result_next;

    logic                          accept;
    logic                          shrink;
    logic                          out_free;
    logic                          emit;
    logic [POS_W-1:0]              len;
    logic                          wr_en;
    logic                          rd_en;
    logic [mwsl_pkg::VALUE_W-1:0]  rd_data;

    assign sample_stall = (state_reg != mwsl_pkg::ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign len      = back_reg - front_reg;
    assign shrink   = (front_reg < back_reg) && (CMP_W'(sum_reg) >= CMP_W'(target_reg));
    assign out_free = !result_valid_reg || !result_stall;
    assign emit     = (state_reg == mwsl_pkg::ST_CHECK) && !shrink && last_reg && out_free;
    assign wr_en    = accept && (back_reg < MAX_POS);
    assign rd_en    = (state_reg == mwsl_pkg::ST_CHECK) && shrink;

    mwsl_store #(
        .DEPTH  (MAX_ITEMS),
        .DATA_W (mwsl_pkg::VALUE_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (back_reg[ADDR_W-1:0]),
        .wr_data (sample.value),
        .rd_en   (rd_en),
        .rd_addr (front_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwsl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mwsl_pkg::ST_CHECK;
                end
            end
            mwsl_pkg::ST_CHECK:
            begin
                if (shrink)
                begin
                    state_next = mwsl_pkg::ST_WAIT;
                end
                else if (!last_reg || out_free)
                begin
                    state_next = mwsl_pkg::ST_IDLE;
                end
            end
            mwsl_pkg::ST_WAIT:
            begin
                state_next = mwsl_pkg::ST_CHECK;
            end
            default:
            begin
                state_next = mwsl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        front_next        = front_reg;
        back_next         = back_reg;
        sum_next          = sum_reg;
        best_next         = best_reg;
        found_next        = found_reg;
        ovf_next          = ovf_reg;
        last_next         = last_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            mwsl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = sample.last;
                    if (back_reg < MAX_POS)
                    begin
                        back_next = back_reg + POS_W'(1);
                        sum_next  = sum_reg + SUM_W'(sample.value);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            mwsl_pkg::ST_CHECK:
            begin
                if (shrink)
                begin
                    if (!found_reg || (len < best_reg))
                    begin
                        best_next  = len;
                        found_next = 1'b1;
                    end
                    front_next = front_reg + POS_W'(1);
                end
                else if (emit)
                begin
                    result_next.min_length = found_reg ? mwsl_pkg::LEN_W'(best_reg) : '0;
                    result_next.overflow   = ovf_reg;
                    result_valid_next      = 1'b1;
                    front_next             = '0;
                    back_next              = '0;
                    sum_next               = '0;
                    best_next              = '0;
                    found_next             = 1'b0;
                    ovf_next               = 1'b0;
                    last_next              = 1'b0;
                end
            end
            mwsl_pkg::ST_WAIT:
            begin
                sum_next = sum_reg - SUM_W'(rd_data);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mwsl_pkg::ST_IDLE;
            front_reg        <= '0;
            back_reg         <= '0;
            sum_reg          <= '0;
            best_reg         <= '0;
            found_reg        <= 1'b0;
            ovf_reg          <= 1'b0;
            last_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            target_reg       <= mwsl_pkg::TARGET_W'(1);
        end
        else
        begin
            state_reg        <= state_next;
            front_reg        <= front_next;
            back_reg         <= back_next;
            sum_reg          <= sum_next;
            best_reg         <= best_next;
            found_reg        <= found_next;
            ovf_reg          <= ovf_next;
            last_reg         <= last_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                target_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // window never runs past its back
    `ASSERT_ALWAYS(a_front_le_back, front_reg <= back_reg)
    // a read result is only consumed right after the read was issued
    `ASSERT_IMPL(a_wait_after_check, state_reg == mwsl_pkg::ST_WAIT, $past(rd_en))
    // a recorded best length is never empty
    `ASSERT_IMPL(a_best_nonzero, found_reg, best_reg != '0)
    // a pending result word is not overwritten
    `ASSERT_IMPL(a_no_result_overrun, result_valid_reg && result_stall, !emit)

endmodule

// ----- bench/mwsl_result_check.sv -----
// Scoreboard for min_window_sum_length: watches the sample, result and target
// write channels, predicts each sequence's answer and compares it field by field.
// Depends on mwsl_pkg.
module mwsl_result_check #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    input  logic                           sample_stall,
    input  mwsl_pkg::sample_t              sample,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  mwsl_pkg::result_t              result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mwsl_pkg::TARGET_W-1:0]  cfg_data,
    output int                             mismatch_count,
    output int                             answers_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [mwsl_pkg::VALUE_W-1:0]  window_words [MAX_ITEMS];
    int unsigned                   head_pos;
    int unsigned                   tail_pos;
    int unsigned                   best_len;
    logic [31:0]                   running_sum;
    bit                            seen_hit;
    bit                            dropped_any;
    logic [mwsl_pkg::TARGET_W-1:0] threshold;
    mwsl_pkg::result_t             length_answers [$];

    initial mismatch_count = 0;
    assign answers_pending = length_answers.size();

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic clear_window();
        head_pos    = 0;
        tail_pos    = 0;
        best_len    = 0;
        running_sum = '0;
        seen_hit    = 1'b0;
        dropped_any = 1'b0;
    endtask

    task automatic take_word(input mwsl_pkg::sample_t w);
        mwsl_pkg::result_t ans;
        if (tail_pos < MAX_ITEMS)
        begin
            window_words[tail_pos] = w.value;
            tail_pos++;
            running_sum += w.value;
        end
        else
        begin
            dropped_any = 1'b1;
        end
        while (head_pos < tail_pos && running_sum >= threshold)
        begin
            if (!seen_hit || tail_pos - head_pos < best_len)
            begin
                best_len = tail_pos - head_pos;
                seen_hit = 1'b1;
            end
            running_sum -= window_words[head_pos];
            head_pos++;
        end
        if (w.last)
        begin
            ans.min_length = seen_hit ? best_len[mwsl_pkg::LEN_W-1:0] : '0;
            ans.overflow   = dropped_any;
            length_answers.push_back(ans);
            clear_window();
        end
    endtask

    task automatic check_result(input mwsl_pkg::result_t got);
        mwsl_pkg::result_t want;
        if (length_answers.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result word: min_length %0d overflow %0d",
                                      got.min_length, got.overflow));
        end
        else
        begin
            want = length_answers.pop_front();
            if (got.min_length !== want.min_length)
                report_mismatch($sformatf("min_length %0d, expected %0d",
                                          got.min_length, want.min_length));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("overflow %0d, expected %0d",
                                          got.overflow, want.overflow));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            threshold = mwsl_pkg::TARGET_W'(1);
            length_answers.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
            if (sample_valid && !sample_stall)
                take_word(sample);
            if (result_valid && !result_stall)
                check_result(result);
        end
    end

endmodule

// ----- bench/min_window_sum_length_test.sv -----
// Top of the min_window_sum_length bench: clock, reset, target writes, sample
// sequences and result-side stalls; the verdict comes from mwsl_result_check.
// Depends on mwsl_pkg, min_window_sum_length and mwsl_result_check.
module min_window_sum_length_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 120;
    localparam int PHASE_ITEMS  = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_GAP   = 20;
    localparam logic [mwsl_pkg::TARGET_W-1:0] TARGET_MAX  = '1;
    localparam logic [mwsl_pkg::TARGET_W-1:0] FULL_WINDOW =
        mwsl_pkg::TARGET_W'(WINDOW_DEPTH * 65535);

    localparam int STYLE_ANY   = 0;
    localparam int STYLE_SMALL = 1;
    localparam int STYLE_ZEROS = 2;
    localparam int STYLE_HIGH  = 3;

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_stall;
    mwsl_pkg::sample_t             sample;
    logic                          result_valid;
    logic                          result_stall;
    mwsl_pkg::result_t             result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mwsl_pkg::TARGET_W-1:0] cfg_data;
    logic                          hold_request;
    int                            mismatch_count;
    int                            answers_pending;
    int                            burst_left;
    int                            idle_cycles;

    min_window_sum_length #(
        .MAX_ITEMS(WINDOW_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    mwsl_result_check #(
        .MAX_ITEMS(WINDOW_DEPTH)
    ) scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .answers_pending (answers_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall stretches, plus one long hold-off on request
    initial
    begin : result_side
        int unsigned pct;
        int unsigned stretch;
        bit          held;
        result_stall <= 1'b0;
        held = 1'b0;
        forever
        begin
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 20;
                2:       pct = 50;
                default: pct = 85;
            endcase
            stretch = $urandom_range(20, 200);
            while (stretch > 0)
            begin
                @(posedge clk);
                if (hold_request && !held)
                begin
                    held = 1'b1;
                    result_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                result_stall <= ($urandom_range(0, 99) < pct);
                stretch--;
            end
        end
    end

    function automatic logic [mwsl_pkg::VALUE_W-1:0] pick_value(input int style);
        case (style)
            STYLE_SMALL: return mwsl_pkg::VALUE_W'($urandom_range(0, 15));
            STYLE_ZEROS: return ($urandom_range(0, 7) == 0)
                                ? mwsl_pkg::VALUE_W'($urandom_range(0, 65535)) : '0;
            STYLE_HIGH:  return mwsl_pkg::VALUE_W'($urandom_range(65000, 65535));
            default:     return mwsl_pkg::VALUE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(input logic [mwsl_pkg::VALUE_W-1:0] v, input logic l);
        bit          taken;
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        sample_valid <= 1'b1;
        sample       <= '{value: v, last: l};
        do
        begin
            @(negedge clk);
            taken = !sample_stall;
            @(posedge clk);
        end
        while (!taken);
        burst_left--;
    endtask

    task automatic send_sequence(input int len, input int style);
        for (int i = 0; i < len; i++)
            send_word(pick_value(style), i == len - 1);
    endtask

    // wait until every answer is back and the block has gone quiet
    task automatic settle();
        sample_valid <= 1'b0;
        do
            @(negedge clk);
        while (answers_pending != 0);
        repeat (SETTLE_GAP) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_target(input logic [mwsl_pkg::TARGET_W-1:0] v);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                            random_items;
        int                            phase_items;
        int                            phase;
        int                            len;
        logic [mwsl_pkg::TARGET_W-1:0] new_target;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        hold_request <= 1'b0;
        burst_left   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset target of 1
        send_word(16'd0, 1'b1);
        send_word(16'hFFFF, 1'b1);
        send_word(16'd0, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd5, 1'b1);
        // zero target: any stored word gives length 1
        settle();
        write_target('0);
        send_word(16'd0, 1'b0);
        send_word(16'd0, 1'b1);
        settle();
        write_target(TARGET_MAX);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b1);
        settle();
        write_target(mwsl_pkg::TARGET_W'(100));
        send_word(16'd60, 1'b0);
        send_word(16'd30, 1'b0);
        send_word(16'd20, 1'b0);
        send_word(16'd90, 1'b0);
        send_word(16'd5, 1'b1);
        settle();
        write_target(mwsl_pkg::TARGET_W'(1));
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b1);

        // store full: only the whole window reaches target, extra words dropped
        settle();
        write_target(FULL_WINDOW);
        for (int i = 0; i < WINDOW_DEPTH + 6; i++)
            send_word(16'hFFFF, i == WINDOW_DEPTH + 5);

        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            case (phase % 6)
                0:       new_target = mwsl_pkg::TARGET_W'($urandom_range(1, 40));
                1:       new_target = mwsl_pkg::TARGET_W'($urandom_range(1, 200));
                2:       new_target = mwsl_pkg::TARGET_W'($urandom_range(65535, 300000));
                3:       new_target = mwsl_pkg::TARGET_W'($urandom_range(1000, 65535));
                4:       new_target = TARGET_MAX;
                default: new_target = mwsl_pkg::TARGET_W'($urandom_range(1, 2000000));
            endcase
            write_target(new_target);
            if (phase == 1)
                hold_request <= 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (phase == 1)
                    len = $urandom_range(1, 3);
                else if ($urandom_range(0, 99) < 70)
                    len = $urandom_range(1, 12);
                else if ($urandom_range(0, 99) < 85)
                    len = $urandom_range(13, 64);
                else
                    len = $urandom_range(65, 200);
                send_sequence(len, $urandom_range(STYLE_ANY, STYLE_HIGH));
                phase_items += len;
            end
            random_items += phase_items;
            phase++;
        end

        settle();
        if (mismatch_count == 0 && answers_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
